### design/joystick_deadzone_debounce_unit_assert.svh
`ifndef JOYSTICK_DEADZONE_DEBOUNCE_UNIT_ASSERT_SVH
`define JOYSTICK_DEADZONE_DEBOUNCE_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk with rst masking
`define JDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/jdd_pkg.sv
package jdd_pkg;

  localparam int AXIS_W      = 12;
  localparam int GAIN_W      = 8;
  localparam int DZ_W        = 12;
  localparam int CMD_W       = 9;
  localparam int HIST_W      = 4;
  localparam int SCALE_SHIFT = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd2;

  localparam logic [GAIN_W-1:0] MOVE_GAIN_RST = 8'd1;
  localparam logic [GAIN_W-1:0] TURN_GAIN_RST = 8'd1;
  localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 12'd300;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] move_gain;
    logic [GAIN_W-1:0] turn_gain;
    logic [DZ_W-1:0]   dead_zone;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic read;
    logic door_pressed;
    logic fire_pressed;
  } btn_ctrl_t;

endpackage

### design/joystick_deadzone_debounce_unit.sv
// path: a read beat waits in the input register, then is registered into the output register
// throughput: one beat per cycle while the output is not stalled, ticks and reads mixed freely
// ticks give no output beat and never wait on the output side
// a stalled output holds back reads in the input register only
// reset: gains 1, dead zone 300, button histories and door level cleared
`include "joystick_deadzone_debounce_unit_assert.svh"

module joystick_deadzone_debounce_unit import jdd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic                    door_pin,
  input  logic                    fire_pin,
  input  logic [AXIS_W-1:0]       axis_y,
  input  logic [AXIS_W-1:0]       axis_x,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CMD_W-1:0] move,
  output logic signed [CMD_W-1:0] turn,
  output logic                    fire,
  output logic                    door
);

  cfg_t cfg;

  logic              s1_valid;
  logic              s1_kind;
  logic              s1_door_pin;
  logic              s1_fire_pin;
  logic [AXIS_W-1:0] s1_axis_y;
  logic [AXIS_W-1:0] s1_axis_x;

  logic                    out_free;
  logic                    s1_go;
  logic                    read_go;
  btn_ctrl_t               btn_ctrl;
  logic signed [CMD_W-1:0] move_res;
  logic signed [CMD_W-1:0] turn_res;
  logic                    fire_res;
  logic                    door_res;

  jdd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && ((s1_kind == KIND_TICK) || out_free);
  assign read_go  = s1_go && (s1_kind == KIND_READ);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_kind     <= kind;
      s1_door_pin <= door_pin;
      s1_fire_pin <= fire_pin;
      s1_axis_y   <= axis_y;
      s1_axis_x   <= axis_x;
    end
  end

  // pins are active low
  assign btn_ctrl.tick         = s1_go && (s1_kind == KIND_TICK);
  assign btn_ctrl.read         = read_go;
  assign btn_ctrl.door_pressed = !s1_door_pin;
  assign btn_ctrl.fire_pressed = !s1_fire_pin;

  jdd_btn u_btn (
    .clk  (clk),
    .rst  (rst),
    .ctrl (btn_ctrl),
    .fire (fire_res),
    .door (door_res)
  );

  jdd_axis u_axis_y (
    .sample    (s1_axis_y),
    .gain      (cfg.move_gain),
    .dead_zone (cfg.dead_zone),
    .result    (move_res)
  );

  jdd_axis u_axis_x (
    .sample    (s1_axis_x),
    .gain      (cfg.turn_gain),
    .dead_zone (cfg.dead_zone),
    .result    (turn_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (read_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (read_go) begin
      move <= move_res;
      turn <= turn_res;
      fire <= fire_res;
      door <= door_res;
    end
  end

  `JDD_ASSERT_NOW(a_tick_never_stalls, s1_valid && (s1_kind == KIND_TICK), s1_go,
    "tick held in input register")
  `JDD_ASSERT_NEXT(a_read_lands, read_go, out_valid && (door == $past(door_res)),
    "read beat did not reach output register")
  `JDD_ASSERT_NEXT(a_input_captured, in_valid && in_ready, s1_valid,
    "accepted beat lost from input register")

endmodule

### design/jdd_cfg.sv
module jdd_cfg import jdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_gain <= MOVE_GAIN_RST;
      cfg.turn_gain <= TURN_GAIN_RST;
      cfg.dead_zone <= DEAD_ZONE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_GAIN: cfg.move_gain <= cfg_data[GAIN_W-1:0];
        REG_TURN_GAIN: cfg.turn_gain <= cfg_data[GAIN_W-1:0];
        REG_DEAD_ZONE: cfg.dead_zone <= cfg_data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/jdd_axis.sv
module jdd_axis import jdd_pkg::*; (
  input  logic [AXIS_W-1:0]       sample,
  input  logic [GAIN_W-1:0]       gain,
  input  logic [DZ_W-1:0]         dead_zone,
  output logic signed [CMD_W-1:0] result
);

  localparam int C_W    = AXIS_W + 1;
  localparam int CMP_W  = DZ_W + 2;
  localparam int PROD_W = C_W + GAIN_W + 1;

  logic signed [C_W-1:0]    centred;
  logic signed [CMP_W-1:0]  c_ext;
  logic signed [CMP_W-1:0]  dz_ext;
  logic                     in_zone;
  logic signed [C_W-1:0]    c_kept;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;

  // sample - 2048: flipping the top bit gives the offset in two's complement
  assign centred = $signed({~sample[AXIS_W-1], ~sample[AXIS_W-1], sample[AXIS_W-2:0]});
  assign c_ext   = CMP_W'(centred);
  assign dz_ext  = $signed({2'b00, dead_zone});
  assign in_zone = (c_ext > -dz_ext) && (c_ext < dz_ext);
  assign c_kept  = in_zone ? '0 : centred;

  assign prod = PROD_W'(c_kept) * $signed({1'b0, gain});

  // round toward zero before the arithmetic shift
  assign biased = prod + (prod[PROD_W-1] ? PROD_W'((1 << SCALE_SHIFT) - 1) : '0);
  assign result = biased[SCALE_SHIFT +: CMD_W];

endmodule

### design/jdd_btn.sv
module jdd_btn import jdd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  btn_ctrl_t ctrl,
  output logic      fire,
  output logic      door
);

  logic [HIST_W-1:0] door_history;
  logic [HIST_W-1:0] fire_history;
  logic              door_last_level;
  logic              door_now;

  assign door_now = &door_history;
  assign fire     = &fire_history;
  assign door     = door_now && !door_last_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      door_history    <= '0;
      fire_history    <= '0;
      door_last_level <= 1'b0;
    end else begin
      if (ctrl.tick) begin
        door_history <= {door_history[HIST_W-2:0], ctrl.door_pressed};
        fire_history <= {fire_history[HIST_W-2:0], ctrl.fire_pressed};
      end
      if (ctrl.read) begin
        door_last_level <= door_now;
      end
    end
  end

endmodule

### test/joystick_deadzone_debounce_unit_test.sv
module joystick_deadzone_debounce_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jdd_pkg::*;

  localparam int AXIS_MID  = 2048;
  localparam int SCALE_DIV = 1 << SCALE_SHIFT;
  localparam int AXIS_MAX  = (1 << AXIS_W) - 1;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic              kind;
    logic              door_pin;
    logic              fire_pin;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_x;
  } stick_beat_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] move;
    logic signed [CMD_W-1:0] turn;
    logic                    fire;
    logic                    door;
  } stick_cmd_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    kind = KIND_TICK;
  logic                    door_pin = 1'b1;
  logic                    fire_pin = 1'b1;
  logic [AXIS_W-1:0]       axis_y = '0;
  logic [AXIS_W-1:0]       axis_x = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [CMD_W-1:0] move;
  logic signed [CMD_W-1:0] turn;
  logic                    fire;
  logic                    door;

  joystick_deadzone_debounce_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .door_pin  (door_pin),
    .fire_pin  (fire_pin),
    .axis_y    (axis_y),
    .axis_x    (axis_x),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .move      (move),
    .turn      (turn),
    .fire      (fire),
    .door      (door)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stimulus and expected commands
  stick_beat_t pending_beats[$];
  stick_cmd_t  expected_cmds[$];
  int          pushed_total = 0;
  int          accepted_total = 0;

  // predictor copy of the registers and button state
  logic [GAIN_W-1:0] move_gain_now = MOVE_GAIN_RST;
  logic [GAIN_W-1:0] turn_gain_now = TURN_GAIN_RST;
  logic [DZ_W-1:0]   dead_zone_now = DEAD_ZONE_RST;
  logic [HIST_W-1:0] door_shift = '0;
  logic [HIST_W-1:0] fire_shift = '0;
  logic              door_level_seen = 1'b0;

  int fail_count = 0;
  int checked_count = 0;
  int tick_count = 0;
  int read_count = 0;
  int fire_seen = 0;
  int door_pulses = 0;
  int settings_count = 1;

  bit calm = 1'b0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int send_gap = 0;
  int recv_gap = 0;
  logic in_took = 1'b0;
  bit door_down = 1'b0;
  bit fire_down = 1'b0;

  function automatic logic signed [CMD_W-1:0] shape_axis(logic [AXIS_W-1:0] sample,
                                                         logic [GAIN_W-1:0] gain,
                                                         logic [DZ_W-1:0] zone);
    int offset;
    int edge_lim;
    int scaled;
    offset = int'(sample) - AXIS_MID;
    edge_lim = int'(zone);
    if (offset > -edge_lim && offset < edge_lim) offset = 0;
    // int division truncates toward zero
    scaled = (offset * int'(gain)) / SCALE_DIV;
    return scaled[CMD_W-1:0];
  endfunction

  // sender: holds a beat until accepted, then takes the next one, with random gaps unless calm
  always @(negedge clk) begin
    stick_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        kind <= b.kind;
        door_pin <= b.door_pin;
        fire_pin <= b.fire_pin;
        axis_y <= b.axis_y;
        axis_x <= b.axis_x;
        if (!calm && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 11) == 0) recv_gap <= $urandom_range(1, 14);
    end
  end

  // predict on input beats, check output beats
  always @(posedge clk) begin
    stick_cmd_t want;
    stick_cmd_t got;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        accepted_total++;
        if (kind == KIND_TICK) begin
          tick_count++;
          door_shift = {door_shift[HIST_W-2:0], ~door_pin};
          fire_shift = {fire_shift[HIST_W-2:0], ~fire_pin};
        end else begin
          read_count++;
          want.move = shape_axis(axis_y, move_gain_now, dead_zone_now);
          want.turn = shape_axis(axis_x, turn_gain_now, dead_zone_now);
          want.fire = &fire_shift;
          want.door = (&door_shift) && !door_level_seen;
          door_level_seen = &door_shift;
          expected_cmds.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        got = '{move, turn, fire, door};
        if (expected_cmds.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: move %0d turn %0d fire %b door %b",
                     got.move, got.turn, got.fire, got.door);
        end else begin
          want = expected_cmds.pop_front();
          checked_count++;
          if (want.fire) fire_seen++;
          if (want.door) door_pulses++;
          if (got.move !== want.move || got.turn !== want.turn ||
              got.fire !== want.fire || got.door !== want.door) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected move %0d turn %0d fire %b door %b, got move %0d turn %0d fire %b door %b",
                       checked_count, want.move, want.turn, want.fire, want.door,
                       got.move, got.turn, got.fire, got.door);
          end
        end
      end
    end
  end

  task automatic push_beat(input stick_beat_t b);
    pending_beats.push_back(b);
    pushed_total++;
  endtask

  // axis fields of a tick are don't-care, so fill them at random
  task automatic push_tick(input logic door_lvl, input logic fire_lvl);
    stick_beat_t b;
    b.kind = KIND_TICK;
    b.door_pin = door_lvl;
    b.fire_pin = fire_lvl;
    b.axis_y = AXIS_W'($urandom);
    b.axis_x = AXIS_W'($urandom);
    push_beat(b);
  endtask

  task automatic push_read(input int y, input int x);
    stick_beat_t b;
    b.kind = KIND_READ;
    b.door_pin = 1'($urandom);
    b.fire_pin = 1'($urandom);
    b.axis_y = y[AXIS_W-1:0];
    b.axis_x = x[AXIS_W-1:0];
    push_beat(b);
  endtask

  function automatic int pick_axis(input int zone);
    int v;
    case ($urandom_range(0, 5))
      0: v = AXIS_MID - zone + int'($urandom_range(0, 2)) - 1;
      1: v = AXIS_MID + zone + int'($urandom_range(0, 2)) - 1;
      2: v = $urandom_range(0, 1) ? 0 : AXIS_MAX;
      3: v = AXIS_MID + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(0, AXIS_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > AXIS_MAX) v = AXIS_MAX;
    return v;
  endfunction

  // button levels run in stretches so the debounce fills, with rare glitches
  task automatic random_phase(input int n);
    int i;
    bit door_glitch;
    bit fire_glitch;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 5) == 0) door_down = !door_down;
        if ($urandom_range(0, 5) == 0) fire_down = !fire_down;
        door_glitch = ($urandom_range(0, 11) == 0);
        fire_glitch = ($urandom_range(0, 11) == 0);
        push_tick(!(door_down ^ door_glitch), !(fire_down ^ fire_glitch));
      end else begin
        push_read(pick_axis(dead_zone_now), pick_axis(dead_zone_now));
      end
    end
  endtask

  task automatic settle(input int extra);
    while (accepted_total != pushed_total || expected_cmds.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MOVE_GAIN: move_gain_now = val[GAIN_W-1:0];
      REG_TURN_GAIN: turn_gain_now = val[GAIN_W-1:0];
      REG_DEAD_ZONE: dead_zone_now = val[DZ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // only called once the block has drained
  task automatic retune(input int mg, input int tg, input int dz);
    set_reg(REG_MOVE_GAIN, mg[CFG_DATA_W-1:0]);
    set_reg(REG_TURN_GAIN, tg[CFG_DATA_W-1:0]);
    set_reg(REG_DEAD_ZONE, dz[CFG_DATA_W-1:0]);
    settings_count++;
  endtask

  task automatic retune_random();
    int dz;
    dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, AXIS_MAX) : $urandom_range(0, 700);
    retune($urandom_range(0, 4095), $urandom_range(0, 4095), dz);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset settings: extremes and both edges of the dead zone
    push_read(0, AXIS_MAX);
    push_read(AXIS_MAX, 0);
    push_read(AXIS_MID, AXIS_MID);
    push_read(AXIS_MID - 300, AXIS_MID + 300);
    push_read(AXIS_MID - 299, AXIS_MID + 299);
    // four pressed ticks: fire high, door pulses once then holds
    repeat (4) push_tick(1'b0, 1'b0);
    push_read(AXIS_MID, AXIS_MID);
    push_read(AXIS_MID, AXIS_MID);
    push_tick(1'b1, 1'b1);
    push_read(AXIS_MID, AXIS_MID);
    repeat (4) push_tick(1'b0, 1'b1);
    push_read(AXIS_MID, AXIS_MID);
    settle(4);

    // top gains, no dead zone
    retune(255, 255, 0);
    push_read(0, AXIS_MAX);
    push_read(AXIS_MAX, 0);
    push_read(AXIS_MID - 1, AXIS_MID + 1);
    random_phase(400);
    settle(4);

    // dead zone at full scale, zero turn gain
    retune(255, 0, 2048);
    push_read(0, 0);
    push_read(AXIS_MAX, AXIS_MAX);
    random_phase(150);
    settle(4);

    // widest dead zone; output held off long enough to back up the input
    retune(12'h3C8, 7, AXIS_MAX);
    hold_asked++;
    random_phase(300);
    settle(4);

    retune_random();
    random_phase(300);
    settle(4);

    retune_random();
    random_phase(300);
    settle(4);

    // last stretch runs without idling on either side
    calm = 1'b1;
    retune_random();
    random_phase(300);
    settle(10);

    $display("covered %0d ticks and %0d reads over %0d register settings",
             tick_count, read_count, settings_count);
    $display("%0d results checked, %0d with fire, %0d door pulses, %0d mismatches",
             checked_count, fire_seen, door_pulses, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("Regression FAIL");
    $finish;
  end

endmodule
